// ----- design/sfr_pkg.sv -----
// shared constants, register codes and types for the stream find-and-replace block
package sfr_pkg;

    localparam int BYTE_W          = 8;
    localparam int MAX_PATTERN     = 8;
    localparam int MAX_REPLACEMENT = 8;
    localparam int LIST_DEPTH      = 8;
    localparam int LEN_W           = 4;
    localparam int CNT_W           = 4;
    localparam int IDX_W           = 3;
    localparam int DATA_W          = 64;
    localparam int ADDR_W          = 5;
    localparam int REG_IDX_W       = 2;

    // register index, taken from paddr bits above the 8-byte slot
    typedef enum logic [REG_IDX_W-1:0] {
        REG_PATTERN     = 2'd0,
        REG_PATTERN_LEN = 2'd1,
        REG_REPLACE     = 2'd2,
        REG_REPLACE_LEN = 2'd3
    } t_reg_idx;

    // configuration as seen by the datapath, lengths already clamped
    typedef struct packed {
        logic [MAX_PATTERN-1:0][BYTE_W-1:0]     pat;
        logic [LEN_W-1:0]                       plen;
        logic [MAX_REPLACEMENT-1:0][BYTE_W-1:0] rep;
        logic [LEN_W-1:0]                       rlen;
    } t_cfg;

    // result words produced by one input word
    typedef struct packed {
        logic [LIST_DEPTH-1:0][BYTE_W-1:0] data;
        logic [CNT_W-1:0]                  cnt;
        logic                              last;
        logic                              bare;
    } t_list;

endpackage

// ----- design/sfr_cfg.sv -----
// configuration registers behind the apb-style port
module sfr_cfg import sfr_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output t_cfg              o_cfg,
    output logic              o_clr
);

    logic [DATA_W-1:0] r_pat;
    logic [LEN_W-1:0]  r_plen;
    logic [DATA_W-1:0] r_rep;
    logic [LEN_W-1:0]  r_rlen;
    logic              wr_en;
    t_reg_idx          reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = t_reg_idx'(paddr[ADDR_W-1 -: REG_IDX_W]);

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat  <= '0;
            r_plen <= '0;
            r_rep  <= '0;
            r_rlen <= '0;
        end else if (wr_en) begin
            case (reg_idx)
                REG_PATTERN:     r_pat  <= pwdata;
                REG_PATTERN_LEN: r_plen <= pwdata[LEN_W-1:0];
                REG_REPLACE:     r_rep  <= pwdata;
                REG_REPLACE_LEN: r_rlen <= pwdata[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    // any pattern write drops a partial match
    assign o_clr = wr_en && (reg_idx == REG_PATTERN || reg_idx == REG_PATTERN_LEN);

    // read mux
    always_comb begin
        case (reg_idx)
            REG_PATTERN:     prdata = r_pat;
            REG_PATTERN_LEN: prdata = DATA_W'(r_plen);
            REG_REPLACE:     prdata = r_rep;
            REG_REPLACE_LEN: prdata = DATA_W'(r_rlen);
            default:         prdata = '0;
        endcase
    end

    // clamp lengths to the storage depth
    always_comb begin
        o_cfg.pat  = r_pat;
        o_cfg.rep  = r_rep;
        o_cfg.plen = (r_plen > LEN_W'(MAX_PATTERN)) ? LEN_W'(MAX_PATTERN) : r_plen;
        o_cfg.rlen = (r_rlen > LEN_W'(MAX_REPLACEMENT)) ? LEN_W'(MAX_REPLACEMENT) : r_rlen;
    end

endmodule

// ----- design/sfr_match.sv -----
// input register, held partial match and single-pass match evaluation
module sfr_match import sfr_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cfg              i_cfg,
    input  logic              i_clr,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [BYTE_W-1:0] i_byte,
    input  logic              i_last,
    input  logic              i_free,
    output logic              o_load,
    output t_list             o_list,
    output logic [CNT_W-1:0]  o_held_cnt
);

    logic                                r_in_valid;
    logic [BYTE_W-1:0]                   r_in_byte;
    logic                                r_in_last;
    logic [MAX_PATTERN-1:0][BYTE_W-1:0]  r_held;
    logic [CNT_W-1:0]                    r_held_cnt;
    logic [MAX_PATTERN-1:0][BYTE_W-1:0]  n_held;
    logic [CNT_W-1:0]                    n_held_cnt;
    logic [IDX_W-1:0]                    h_eff;
    logic [CNT_W-1:0]                    n_cand;
    logic [MAX_PATTERN-1:0][BYTE_W-1:0]  cand;
    logic [MAX_PATTERN-1:0]              ok;
    logic [CNT_W-1:0]                    s_sel;
    logic                                match;

    assign o_load     = r_in_valid && i_free;
    assign o_ready    = !r_in_valid || o_load;
    assign o_held_cnt = r_held_cnt;

    // input word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_in_valid <= 1'b1;
        end else if (o_load) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_in_byte <= i_byte;
            r_in_last <= i_last;
        end
    end

    // held bytes: payload, no reset
    always_ff @(posedge i_clk) begin
        if (o_load) begin
            r_held <= n_held;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_cnt <= '0;
        end else if (i_clr) begin
            r_held_cnt <= '0;
        end else if (o_load) begin
            r_held_cnt <= n_held_cnt;
        end
    end

    // candidate window: held bytes plus the new byte
    always_comb begin
        if (r_held_cnt >= i_cfg.plen) begin
            h_eff = '0;
        end else begin
            h_eff = r_held_cnt[IDX_W-1:0];
        end
        n_cand = CNT_W'(h_eff) + CNT_W'(1);
        for (int i = 0; i < MAX_PATTERN; i++) begin
            cand[i] = (IDX_W'(i) == h_eff) ? r_in_byte : r_held[i];
        end
    end

    // every start offset checked against the pattern prefix in parallel
    always_comb begin
        for (int s = 0; s < MAX_PATTERN; s++) begin
            ok[s] = 1'b1;
            if (CNT_W'(s) >= n_cand) begin
                ok[s] = 1'b0;
            end
            if ((n_cand - CNT_W'(s)) > i_cfg.plen) begin
                ok[s] = 1'b0;
            end
            for (int j = 0; j < MAX_PATTERN; j++) begin
                if ((CNT_W'(s + j) < n_cand) && (cand[IDX_W'(s + j)] != i_cfg.pat[j])) begin
                    ok[s] = 1'b0;
                end
            end
        end
    end

    // leftmost offset that still starts a match, window length if none
    always_comb begin
        s_sel = n_cand;
        for (int s = MAX_PATTERN - 1; s >= 0; s--) begin
            if (ok[s]) begin
                s_sel = CNT_W'(s);
            end
        end
        match = (i_cfg.plen != '0) && (s_sel == '0) && (n_cand == i_cfg.plen);
    end

    // next held window and the result list
    always_comb begin
        for (int j = 0; j < MAX_PATTERN; j++) begin
            n_held[j] = cand[IDX_W'(32'(s_sel) + j)];
        end
        if (match || r_in_last) begin
            n_held_cnt = '0;
        end else begin
            n_held_cnt = n_cand - s_sel;
        end

        o_list.last = r_in_last;
        o_list.bare = 1'b0;
        if (match) begin
            o_list.data = i_cfg.rep;
            o_list.cnt  = CNT_W'(i_cfg.rlen);
        end else begin
            o_list.data = cand;
            o_list.cnt  = r_in_last ? n_cand : s_sel;
        end
        if (r_in_last && (o_list.cnt == '0)) begin
            o_list.bare    = 1'b1;
            o_list.cnt     = CNT_W'(1);
            o_list.data[0] = '0;
        end
    end

endmodule

// ----- design/sfr_outq.sv -----
// result register that drains one word per cycle while the receiver is ready
module sfr_outq import sfr_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  t_list             i_list,
    output logic              o_free,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [BYTE_W-1:0] o_byte,
    output logic              o_out_valid,
    output logic              o_last
);

    logic [LIST_DEPTH-1:0][BYTE_W-1:0] r_data;
    logic [CNT_W-1:0]                  r_cnt;
    logic                              r_last;
    logic                              r_bare;
    logic                              pop;

    assign o_valid = (r_cnt != '0);
    assign pop     = o_valid && i_ready;
    assign o_free  = (r_cnt == '0) || ((r_cnt == CNT_W'(1)) && i_ready);

    // count and flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_last <= 1'b0;
            r_bare <= 1'b0;
        end else if (i_load) begin
            r_cnt  <= i_list.cnt;
            r_last <= i_list.last;
            r_bare <= i_list.bare;
        end else if (pop) begin
            r_cnt <= r_cnt - CNT_W'(1);
        end
    end

    // byte list shifts down as words leave
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_data <= i_list.data;
        end else if (pop) begin
            r_data <= {BYTE_W'(0), r_data[LIST_DEPTH-1:1]};
        end
    end

    assign o_byte      = r_data[0];
    assign o_out_valid = !r_bare;
    assign o_last      = r_last && (r_cnt == CNT_W'(1));

endmodule

// ----- design/stream_find_replace.sv -----
// top level of the stream find-and-replace block
// Replaces each leftmost, non-overlapping occurrence of a pattern of up to eight bytes in a
// byte stream with a replacement of zero to eight bytes. An accepted word is registered
// before the match logic sees it, and its results enter the result register when free.
// The block takes one byte per cycle while each byte yields at most one result and the
// receiver is ready; a byte that yields several results (a replacement, a run of released
// bytes or the flush on the last byte) holds the input until the result register has handed
// them out, one word per cycle. A byte with no result does not hold the input. Write
// configuration only while the stream is idle; a pattern write drops any partial match.
module stream_find_replace import sfr_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [BYTE_W-1:0] i_in_byte,
    input  logic              i_in_last,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [BYTE_W-1:0] o_out_byte,
    output logic              o_out_valid,
    output logic              o_out_last,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    t_cfg             cfg;
    logic             clr;
    logic             load;
    logic             free;
    t_list            list;
    logic [CNT_W-1:0] held_cnt;

    // configuration registers
    sfr_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg),
        .o_clr   (clr)
    );

    // match evaluation
    sfr_match u_match (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_clr      (clr),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_byte     (i_in_byte),
        .i_last     (i_in_last),
        .i_free     (free),
        .o_load     (load),
        .o_list     (list),
        .o_held_cnt (held_cnt)
    );

    // result drain
    sfr_outq u_outq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (load),
        .i_list      (list),
        .o_free      (free),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_byte      (o_out_byte),
        .o_out_valid (o_out_valid),
        .o_last      (o_out_last)
    );

    // a partial match is always shorter than the full pattern depth
    a_held_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        held_cnt < CNT_W'(MAX_PATTERN))
        else $error("held count reached pattern depth");

    // the last byte of a text leaves nothing held
    a_last_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load && list.last && !clr) |=> (held_cnt == '0))
        else $error("held bytes survive end of text");

    // a bare end mark is always the final word of its text
    a_bare_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_out_valid) |-> o_out_last)
        else $error("bare word without end mark");

    // a load never lands on a result register that still has words to give
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load && o_valid && !i_ready) |-> 1'b0)
        else $error("result register overwritten");

endmodule

// ----- tb/stream_find_replace_test.sv -----
// testbench for the stream find-and-replace block: directed and random texts with a local model
`timescale 1ns / 1ps

module stream_find_replace_test import sfr_pkg::*;;

    localparam int RESET_CYCLES = 7;
    localparam int DRAIN_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 400_000;
    localparam int RANDOM_WORDS = 220;
    localparam int CALM_WORDS   = 50;
    localparam int REPORT_MAX   = 10;

    // one word of edited text as the block should present it
    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              has_data;
        logic              is_last;
    } t_edit;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_valid;
    logic              o_ready;
    logic [BYTE_W-1:0] i_in_byte;
    logic              i_in_last;
    logic              o_valid;
    logic              i_ready;
    logic [BYTE_W-1:0] o_out_byte;
    logic              o_out_valid;
    logic              o_out_last;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    stream_find_replace dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_in_byte   (i_in_byte),
        .i_in_last   (i_in_last),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_out_byte  (o_out_byte),
        .o_out_valid (o_out_valid),
        .o_out_last  (o_out_last),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    // model copy of the registers and of the partial match
    logic [DATA_W-1:0] cfg_pattern;
    logic [LEN_W-1:0]  cfg_pattern_len;
    logic [DATA_W-1:0] cfg_replace;
    logic [LEN_W-1:0]  cfg_replace_len;
    logic [BYTE_W-1:0] held [MAX_PATTERN];
    int                held_n;

    t_edit             edited_q [$];
    logic [BYTE_W-1:0] text_q [$];
    logic [BYTE_W-1:0] alpha [3];

    int  errors;
    int  words_in;
    int  words_out;
    int  texts;
    int  reg_writes;
    int  cycles;
    int  hold_left;
    int  rx_stall;
    bit  idle_en;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // run limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d words still due", cycles, edited_q.size());
            $display("stream_find_replace_test: errors");
            $finish;
        end
    end

    // receiver: long hold on request, random stall bursts while idling is on
    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                hold_left = hold_left - 1;
                i_ready <= 1'b0;
            end else if (rx_stall > 0) begin
                rx_stall = rx_stall - 1;
                i_ready <= 1'b0;
            end else if (idle_en && $urandom_range(0, 7) == 0) begin
                rx_stall = $urandom_range(1, 15) - 1;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    task automatic note_error(input string what, input t_edit want, input t_edit got);
        errors = errors + 1;
        if (errors <= REPORT_MAX)
            $display("%0t %s: want byte %02h valid %0b last %0b, got byte %02h valid %0b last %0b",
                     $realtime, what, want.data, want.has_data, want.is_last,
                     got.data, got.has_data, got.is_last);
    endtask

    // compare each output word with the oldest predicted one
    always @(posedge i_clk) begin
        t_edit got;
        t_edit want;
        if (i_rst_n && o_valid && i_ready) begin
            got = '{data: o_out_byte, has_data: o_out_valid, is_last: o_out_last};
            words_out = words_out + 1;
            if (edited_q.size() == 0) begin
                note_error("unexpected word", '0, got);
            end else begin
                want = edited_q.pop_front();
                if (got !== want)
                    note_error("mismatch", want, got);
            end
        end
    end

    // predict the words that one input word releases
    task automatic apply_edit(input logic [BYTE_W-1:0] b, input logic last);
        int    plen;
        int    rlen;
        int    n;
        bit    prefix;
        t_edit w;
        plen = (cfg_pattern_len > MAX_PATTERN) ? MAX_PATTERN : int'(cfg_pattern_len);
        rlen = (cfg_replace_len > MAX_REPLACEMENT) ? MAX_REPLACEMENT : int'(cfg_replace_len);
        n = 0;
        if (plen == 0) begin
            held_n = 0;
            edited_q.push_back('{data: b, has_data: 1'b1, is_last: 1'b0});
            n++;
        end else begin
            if (held_n >= plen)
                held_n = 0;
            held[held_n] = b;
            held_n++;
            while (held_n > 0) begin
                prefix = 1'b1;
                for (int i = 0; i < held_n; i++)
                    if (held[i] != cfg_pattern[8*i +: 8])
                        prefix = 1'b0;
                if (prefix) begin
                    // full match: replacement goes out, held bytes are consumed
                    if (held_n == plen) begin
                        for (int i = 0; i < rlen; i++) begin
                            edited_q.push_back('{data: cfg_replace[8*i +: 8], has_data: 1'b1,
                                                 is_last: 1'b0});
                            n++;
                        end
                        held_n = 0;
                    end
                    break;
                end
                // oldest held byte can no longer start a match
                edited_q.push_back('{data: held[0], has_data: 1'b1, is_last: 1'b0});
                n++;
                for (int i = 1; i < held_n; i++)
                    held[i-1] = held[i];
                held_n--;
            end
        end
        if (last) begin
            for (int i = 0; i < held_n; i++) begin
                edited_q.push_back('{data: held[i], has_data: 1'b1, is_last: 1'b0});
                n++;
            end
            held_n = 0;
            if (n == 0) begin
                edited_q.push_back('{data: '0, has_data: 1'b0, is_last: 1'b1});
            end else begin
                w = edited_q.pop_back();
                w.is_last = 1'b1;
                edited_q.push_back(w);
            end
        end
    endtask

    // offer one word, with an optional gap, and predict it once taken
    task automatic send_word(input logic [BYTE_W-1:0] b, input logic last);
        if (idle_en && $urandom_range(0, 5) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge i_clk);
        end
        i_valid   <= 1'b1;
        i_in_byte <= b;
        i_in_last <= last;
        @(posedge i_clk);
        while (!o_ready)
            @(posedge i_clk);
        apply_edit(b, last);
        words_in = words_in + 1;
        @(negedge i_clk);
    endtask

    // send the text held in text_q, marking its final word when asked
    task automatic send_text(input bit end_mark);
        for (int i = 0; i < text_q.size(); i++)
            send_word(text_q[i], end_mark && (i == text_q.size() - 1));
        if (end_mark)
            texts = texts + 1;
    endtask

    // stop offering and wait until every predicted word is out
    task automatic drain();
        i_valid <= 1'b0;
        while (edited_q.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // register write: setup then access cycle
    task automatic write_reg(input t_reg_idx idx, input logic [DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(idx) << 3;
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        reg_writes = reg_writes + 1;
        case (idx)
            REG_PATTERN: begin
                cfg_pattern = value;
                held_n = 0;
            end
            REG_PATTERN_LEN: begin
                cfg_pattern_len = value[LEN_W-1:0];
                held_n = 0;
            end
            REG_REPLACE:     cfg_replace = value;
            REG_REPLACE_LEN: cfg_replace_len = value[LEN_W-1:0];
            default: ;
        endcase
    endtask

    // random setting: small alphabet so matches and retries are common
    task automatic random_config();
        logic [DATA_W-1:0] pat;
        int                pick;
        for (int i = 0; i < 3; i++)
            alpha[i] = 8'($urandom_range(0, 255));
        for (int i = 0; i < MAX_PATTERN; i++)
            pat[8*i +: 8] = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                         : alpha[$urandom_range(0, 2)];
        write_reg(REG_PATTERN, pat);
        pick = $urandom_range(0, 9);
        if (pick == 0)
            write_reg(REG_PATTERN_LEN, DATA_W'(0));
        else if (pick == 1)
            write_reg(REG_PATTERN_LEN, DATA_W'(MAX_PATTERN));
        else if (pick == 2)
            write_reg(REG_PATTERN_LEN, DATA_W'($urandom_range(MAX_PATTERN + 1, 15)));
        else
            write_reg(REG_PATTERN_LEN, DATA_W'($urandom_range(1, 5)));
        write_reg(REG_REPLACE, {$urandom, $urandom});
        write_reg(REG_REPLACE_LEN, DATA_W'($urandom_range(0, 15)));
    endtask

    // build a text mostly from whole and partial copies of the pattern
    task automatic make_text(input int target);
        int plen;
        int pick;
        int cut;
        plen = (cfg_pattern_len > MAX_PATTERN) ? MAX_PATTERN : int'(cfg_pattern_len);
        text_q.delete();
        while (text_q.size() < target) begin
            pick = $urandom_range(0, 9);
            if (plen > 0 && pick < 4) begin
                for (int k = 0; k < plen; k++)
                    text_q.push_back(cfg_pattern[8*k +: 8]);
            end else if (plen > 1 && pick < 6) begin
                cut = $urandom_range(1, plen - 1);
                for (int k = 0; k < cut; k++)
                    text_q.push_back(cfg_pattern[8*k +: 8]);
            end else if (pick < 9) begin
                text_q.push_back(alpha[$urandom_range(0, 2)]);
            end else begin
                text_q.push_back(8'($urandom_range(0, 255)));
            end
        end
    endtask

    // empty pattern after reset: bytes go straight through
    task automatic test_pass_through();
        text_q = '{8'h00, 8'hFF};
        send_text(1'b1);
        drain();
    endtask

    // two-byte pattern with a three-byte replacement, including a retry
    task automatic test_match_and_retry();
        write_reg(REG_PATTERN, 64'h0000_0000_0000_FF00);
        write_reg(REG_PATTERN_LEN, 2);
        write_reg(REG_REPLACE, 64'h0000_0000_005A_5958);
        write_reg(REG_REPLACE_LEN, 3);
        text_q = '{8'h00, 8'hFF, 8'h00, 8'h00, 8'hFF, 8'h01};
        send_text(1'b1);
        drain();
    endtask

    // empty replacement: a match at the end leaves only the bare end mark
    task automatic test_delete_and_bare_end();
        write_reg(REG_REPLACE_LEN, 0);
        text_q = '{8'h00, 8'hFF};
        send_text(1'b1);
        drain();
    endtask

    // partial match flushed by the last word
    task automatic test_partial_at_end();
        text_q = '{8'h00};
        send_text(1'b1);
        drain();
    endtask

    // pattern rewritten with a byte held: the held byte is dropped
    task automatic test_pattern_rewrite();
        text_q = '{8'h00};
        send_text(1'b0);
        drain();
        write_reg(REG_PATTERN, 64'h0000_0000_0000_00FF);
        text_q = '{8'hFF};
        send_text(1'b1);
        drain();
    endtask

    // lengths above eight count as eight; one word releases eight words
    task automatic test_length_clamp();
        write_reg(REG_PATTERN, 64'hAA55_FE01_7F00_FF80);
        write_reg(REG_PATTERN_LEN, 15);
        write_reg(REG_REPLACE, 64'hFFEE_DDCC_BBAA_9900);
        write_reg(REG_REPLACE_LEN, 12);
        text_q.delete();
        for (int k = 0; k < MAX_PATTERN; k++)
            text_q.push_back(cfg_pattern[8*k +: 8]);
        send_text(1'b1);
        drain();
    endtask

    // random settings and texts, some left open across a setting change
    task automatic test_random_texts(input int quota);
        int start;
        start = words_in;
        while (words_in - start < quota) begin
            random_config();
            repeat ($urandom_range(1, 4)) begin
                make_text($urandom_range(1, 24));
                send_text($urandom_range(0, 4) != 0);
            end
            drain();
        end
    endtask

    // receiver holds off for a long stretch while the sender keeps offering
    task automatic test_output_hold();
        write_reg(REG_PATTERN, 64'h0000_0000_0000_0201);
        write_reg(REG_PATTERN_LEN, 2);
        write_reg(REG_REPLACE, 64'h4847_4645_4443_4241);
        write_reg(REG_REPLACE_LEN, DATA_W'(MAX_REPLACEMENT));
        alpha = '{8'h01, 8'h02, 8'h03};
        make_text(40);
        hold_left = 300;
        send_text(1'b1);
        drain();
    endtask

    initial begin
        i_rst_n   <= 1'b0;
        i_valid   <= 1'b0;
        i_in_byte <= '0;
        i_in_last <= 1'b0;
        i_ready   <= 1'b0;
        psel      <= 1'b0;
        penable   <= 1'b0;
        pwrite    <= 1'b0;
        paddr     <= '0;
        pwdata    <= '0;
        cfg_pattern     = '0;
        cfg_pattern_len = '0;
        cfg_replace     = '0;
        cfg_replace_len = '0;
        held_n     = 0;
        errors     = 0;
        words_in   = 0;
        words_out  = 0;
        texts      = 0;
        reg_writes = 0;
        cycles     = 0;
        hold_left  = 0;
        rx_stall   = 0;
        idle_en    = 1'b1;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_pass_through();
        test_match_and_retry();
        test_delete_and_bare_end();
        test_partial_at_end();
        test_pattern_rewrite();
        test_length_clamp();
        test_random_texts(RANDOM_WORDS);
        test_output_hold();
        idle_en = 1'b0;
        test_random_texts(CALM_WORDS);

        $display("covered %0d texts, %0d words in, %0d words out, %0d register writes",
                 texts, words_in, words_out, reg_writes);
        $display("settings included empty and clamped lengths, deletion, retries and a long hold");
        if (errors == 0 && edited_q.size() == 0) begin
            $display("stream_find_replace_test: clean");
        end else begin
            $display("%0d mismatches, %0d words never seen", errors, edited_q.size());
            $display("stream_find_replace_test: errors");
        end
        $finish;
    end

endmodule
